@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/bcrf_pkg.sv @@
// Package for the border fill block: sizes, codes and beat payload types.
package bcrf_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int FUNC_W    = 2;
   localparam int DIM_W     = 7;
   localparam int CSR_IDX_W = 4;

   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic KIND_FILL_DONE = 1'b0;
   localparam logic KIND_READ      = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 4'd1;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              cell_open;
   } req_payload_type;

   typedef struct packed {
      logic result_kind;
      logic cell_value;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic step;
   } cell_ctrl_type;

endpackage

@@ design/border_connected_region_fill.sv @@
// Top level of the border connected region fill block.
//
// Usage: items arrive on the req_ channel (valid/stall); a beat is taken when
// req_valid is high and req_stall is low. func write stores one cell and
// gives no result. func read returns one result beat with result_kind read;
// the cell goes through the row read register and the result register. func
// fill removes every open cell of the rows_in_use x cols_in_use area that
// cannot reach the area border through open 4-neighbors, then returns one
// fill-done beat. Fill runs as row sweeps over the grid memory: each round is
// a down and an up sweep, each row fetched, loaded into the cell row and
// stepped until it settles; rounds repeat until one changes nothing, then an
// apply sweep reads each row and writes it back.
// The csr_ port writes rows_in_use (index 0) and cols_in_use (index 1), is
// always ready, and must only be used while the block is idle.
// Reset (synchronous) returns the controller to idle, drops rsp_valid and
// sets both area registers to 64. Grid contents are not cleared.
// While rsp_stall holds a result, rsp_data is held and req_stall stays high.
module border_connected_region_fill (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bcrf_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bcrf_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bcrf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bcrf_pkg::DIM_W-1:0]          csr_data
);

   localparam int COLS = bcrf_pkg::MAX_COLS;
   localparam int RW   = bcrf_pkg::ROW_W;

   // controller states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;  // read data back from grid memory
   localparam logic [2:0] S_FRD   = 3'd2;  // fetch row for a sweep
   localparam logic [2:0] S_FLOAD = 3'd3;  // load the cell row
   localparam logic [2:0] S_FSTEP = 3'd4;  // spread until the row settles
   localparam logic [2:0] S_ARD   = 3'd5;  // fetch row for apply
   localparam logic [2:0] S_AWR   = 3'd6;  // write back filtered row

   logic [2:0] state_ff, state_in;

   // area registers, stored already clamped to 1..max
   logic [bcrf_pkg::DIM_W-1:0] nr_ff, nr_in;
   logic [bcrf_pkg::DIM_W-1:0] nc_ff, nc_in;

   // sweep control
   logic [RW-1:0]   r_ff, r_in;
   logic            down_ff, down_in;       // sweep direction
   logic            first_ff, first_in;     // first down sweep: marks not yet valid
   logic            pass_chg_ff, pass_chg_in;
   logic [COLS-1:0] prev_reach_ff, prev_reach_in;
   logic [bcrf_pkg::COL_W-1:0] col_ff, col_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   bcrf_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // grid memory (open bits) and mark memory, one row per word
   logic [COLS-1:0] open_mem [bcrf_pkg::MAX_ROWS];
   logic [COLS-1:0] mark_mem [bcrf_pkg::MAX_ROWS];
   logic [COLS-1:0] open_rd_ff, mark_rd_ff;
   logic            open_re, mark_re, open_we, mark_we;
   logic [RW-1:0]   open_raddr, open_waddr;
   logic [COLS-1:0] open_wdata, open_wmask, mark_wdata;

   // cell row
   bcrf_pkg::cell_ctrl_type row_ctrl;
   logic [COLS-1:0] row_open, row_seed, row_reach;
   logic            row_busy;

   logic            req_accept;
   logic [RW-1:0]   last_row;
   logic [bcrf_pkg::COL_W-1:0] last_col;
   logic [COLS-1:0] col_mask, edge_cols, old_mark;
   logic            border_row, last_in_dir, row_chg;

   bcrf_cell_row u_row (
      .clock     (clock),
      .ctrl      (row_ctrl),
      .open_vec  (row_open),
      .seed_vec  (row_seed),
      .reach_vec (row_reach),
      .row_busy  (row_busy)
   );

   assign req_stall  = (state_ff != S_IDLE) | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign last_row = RW'(nr_ff - 7'd1);
   assign last_col = bcrf_pkg::COL_W'(nc_ff - 7'd1);

   always_comb begin
      for (int i = 0; i < COLS; i++) begin
         col_mask[i] = bcrf_pkg::DIM_W'(i) < nc_ff;
      end
   end

   assign edge_cols  = COLS'(1) | (COLS'(1) << last_col);
   assign border_row = (r_ff == '0) || (r_ff == last_row);
   assign old_mark   = first_ff ? '0 : mark_rd_ff;
   assign row_open   = open_rd_ff & col_mask;
   // seeds: border cells, previous row of this sweep, marks of earlier sweeps
   assign row_seed   = row_open & (old_mark | prev_reach_ff |
                                   (border_row ? {COLS{1'b1}} : edge_cols));
   assign row_chg    = row_reach != old_mark;
   assign last_in_dir = down_ff ? (r_ff == last_row) : (r_ff == '0);

   // configuration writes, clamped to the valid range
   always_comb begin
      nr_in = nr_ff;
      nc_in = nc_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == bcrf_pkg::CSR_ROWS_IN_USE) begin
            if (csr_data == '0) nr_in = 7'd1;
            else if (csr_data > bcrf_pkg::DIM_W'(bcrf_pkg::MAX_ROWS))
               nr_in = bcrf_pkg::DIM_W'(bcrf_pkg::MAX_ROWS);
            else nr_in = csr_data;
         end else if (csr_index == bcrf_pkg::CSR_COLS_IN_USE) begin
            if (csr_data == '0) nc_in = 7'd1;
            else if (csr_data > bcrf_pkg::DIM_W'(bcrf_pkg::MAX_COLS))
               nc_in = bcrf_pkg::DIM_W'(bcrf_pkg::MAX_COLS);
            else nc_in = csr_data;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      r_in          = r_ff;
      down_in       = down_ff;
      first_in      = first_ff;
      pass_chg_in   = pass_chg_ff;
      prev_reach_in = prev_reach_ff;
      col_in        = col_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      open_re       = 1'b0;
      mark_re       = 1'b0;
      open_we       = 1'b0;
      mark_we       = 1'b0;
      open_raddr    = r_ff;
      open_waddr    = r_ff;
      open_wdata    = '0;
      open_wmask    = '0;
      mark_wdata    = row_reach;
      row_ctrl      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_data.func)
                  bcrf_pkg::FUNC_WRITE: begin
                     open_we    = 1'b1;
                     open_waddr = req_data.row;
                     open_wmask = COLS'(1) << req_data.col;
                     open_wdata = {COLS{req_data.cell_open}};
                  end
                  bcrf_pkg::FUNC_READ: begin
                     open_re    = 1'b1;
                     open_raddr = req_data.row;
                     col_in     = req_data.col;
                     state_in   = S_READ;
                  end
                  bcrf_pkg::FUNC_FILL: begin
                     r_in          = '0;
                     down_in       = 1'b1;
                     first_in      = 1'b1;
                     pass_chg_in   = 1'b0;
                     prev_reach_in = '0;
                     state_in      = S_FRD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in.result_kind = bcrf_pkg::KIND_READ;
            rsp_data_in.cell_value  = open_rd_ff[col_ff];
            state_in = S_IDLE;
         end
         S_FRD: begin
            open_re  = 1'b1;
            mark_re  = 1'b1;
            state_in = S_FLOAD;
         end
         S_FLOAD: begin
            row_ctrl.load = 1'b1;
            state_in      = S_FSTEP;
         end
         S_FSTEP: begin
            row_ctrl.step = row_busy;
            if (!row_busy) begin
               mark_we       = 1'b1;
               prev_reach_in = row_reach;
               if (row_chg) pass_chg_in = 1'b1;
               state_in = S_FRD;
               if (!last_in_dir) begin
                  r_in = down_ff ? r_ff + 1'b1 : r_ff - 1'b1;
               end else if (down_ff) begin
                  // turn around: up sweep starts at the last row
                  down_in       = 1'b0;
                  first_in      = 1'b0;
                  prev_reach_in = '0;
               end else if (pass_chg_ff || row_chg) begin
                  // something moved this round, sweep again
                  down_in       = 1'b1;
                  pass_chg_in   = 1'b0;
                  prev_reach_in = '0;
               end else begin
                  r_in     = '0;
                  state_in = S_ARD;
               end
            end
         end
         S_ARD: begin
            open_re  = 1'b1;
            mark_re  = 1'b1;
            state_in = S_AWR;
         end
         S_AWR: begin
            open_we    = 1'b1;
            open_wmask = {COLS{1'b1}};
            // unreached open cells in the area become blocked
            open_wdata = (open_rd_ff & ~col_mask) | (open_rd_ff & mark_rd_ff & col_mask);
            if (r_ff == last_row) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.result_kind = bcrf_pkg::KIND_FILL_DONE;
               rsp_data_in.cell_value  = 1'b0;
               state_in = S_IDLE;
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = S_ARD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (open_we) begin
         for (int i = 0; i < COLS; i++) begin
            if (open_wmask[i]) open_mem[open_waddr][i] <= open_wdata[i];
         end
      end
      if (open_re) open_rd_ff <= open_mem[open_raddr];
   end

   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[r_ff] <= mark_wdata;
      if (mark_re) mark_rd_ff <= mark_mem[r_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         nr_ff        <= bcrf_pkg::DIM_W'(bcrf_pkg::MAX_ROWS);
         nc_ff        <= bcrf_pkg::DIM_W'(bcrf_pkg::MAX_COLS);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nr_ff        <= nr_in;
         nc_ff        <= nc_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff          <= r_in;
      down_ff       <= down_in;
      first_ff      <= first_in;
      pass_chg_ff   <= pass_chg_in;
      prev_reach_ff <= prev_reach_in;
      col_ff        <= col_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

@@ design/bcrf_cell.sv @@
// One cell of the propagation row: open bit, reach bit and change flag.
module bcrf_cell (
   input  logic                   clock,
   input  bcrf_pkg::cell_ctrl_type ctrl,
   input  logic                   open_in,
   input  logic                   seed_in,
   input  logic                   left_in,
   input  logic                   right_in,
   output logic                   reach_out,
   output logic                   chg_out
);

   logic open_ff, open_in_w;
   logic reach_ff, reach_in;
   logic chg_ff, chg_in;

   always_comb begin
      open_in_w = open_ff;
      reach_in  = reach_ff;
      chg_in    = chg_ff;
      if (ctrl.load) begin
         open_in_w = open_in;
         reach_in  = seed_in;
         chg_in    = 1'b1;
      end else if (ctrl.step) begin
         reach_in = reach_ff | (open_ff & (left_in | right_in));
         chg_in   = reach_in != reach_ff;
      end
   end

   always_ff @(posedge clock) begin
      open_ff  <= open_in_w;
      reach_ff <= reach_in;
      chg_ff   <= chg_in;
   end

   assign reach_out = reach_ff;
   assign chg_out   = chg_ff;

endmodule

@@ design/bcrf_cell_row.sv @@
// Row of cells, one per grid column; reach spreads one column per step.
module bcrf_cell_row (
   input  logic                          clock,
   input  bcrf_pkg::cell_ctrl_type       ctrl,
   input  logic [bcrf_pkg::MAX_COLS-1:0] open_vec,
   input  logic [bcrf_pkg::MAX_COLS-1:0] seed_vec,
   output logic [bcrf_pkg::MAX_COLS-1:0] reach_vec,
   output logic                          row_busy
);

   logic [bcrf_pkg::MAX_COLS-1:0] chg_vec;
   logic [bcrf_pkg::MAX_COLS+1:0] reach_ext;

   assign reach_ext = {1'b0, reach_vec, 1'b0};

   for (genvar i = 0; i < bcrf_pkg::MAX_COLS; i++) begin : g_cell
      bcrf_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .open_in   (open_vec[i]),
         .seed_in   (seed_vec[i]),
         .left_in   (reach_ext[i]),
         .right_in  (reach_ext[i+2]),
         .reach_out (reach_vec[i]),
         .chg_out   (chg_vec[i])
      );
   end

   // still moving while any cell changed in the last step
   assign row_busy = |chg_vec;

endmodule

@@ design/bcrf_checker.sv @@
// Port-level checker for the border fill block, bound to the top level.
`include "assert_macros.svh"

module bcrf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input bcrf_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input bcrf_pkg::rsp_payload_type rsp_data
);

   logic req_beat, req_beat_read, req_beat_fill;
   logic rsp_held, rsp_fill_done, rsp_read;

   assign req_beat      = req_valid && !req_stall;
   assign req_beat_read = req_beat && req_data.func == bcrf_pkg::FUNC_READ;
   assign req_beat_fill = req_beat && req_data.func == bcrf_pkg::FUNC_FILL;
   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_fill_done = rsp_valid && rsp_data.result_kind == bcrf_pkg::KIND_FILL_DONE;
   assign rsp_read      = rsp_valid && rsp_data.result_kind == bcrf_pkg::KIND_READ;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))
   `ASSERT_SAME(a_fill_value, clock, reset, rsp_fill_done, rsp_data.cell_value == 1'b0)
   `ASSERT_NEXT(a_read_busy, clock, reset, req_beat_read, req_stall)
   `ASSERT_NEXT(a_fill_busy, clock, reset, req_beat_fill, req_stall)
   `ASSERT_SAME(a_read_lat, clock, reset, req_beat_read, ##2 rsp_read)

endmodule

bind border_connected_region_fill bcrf_checker u_bcrf_checker (.*);
